// ===== hw/rtl/llnop_pkg.sv =====
`default_nettype none

package llnop_pkg;

	localparam int POSITION_WIDTH = 16;

	localparam int LINK_TYPE_WIDTH = 4;
	localparam int PADDR_WIDTH = 3;
	localparam int PDATA_WIDTH = 32;

	// register index
	localparam logic REG_LINK_TYPE = 1'b0;

	// link types
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_ETHERNET = 4'd0;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_COOKED_V1 = 4'd1;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_COOKED_V2 = 4'd2;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_RAW = 4'd3;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_NULL = 4'd4;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_LOOP = 4'd5;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_RADIOTAP = 4'd6;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_WLAN = 4'd7;

	// parse stages
	typedef logic [2:0] stage_t;
	localparam stage_t ST_START = 3'd0;
	localparam stage_t ST_ETH = 3'd1;
	localparam stage_t ST_TYPE = 3'd2;
	localparam stage_t ST_RTAP = 3'd3;
	localparam stage_t ST_FC = 3'd4;
	localparam stage_t ST_LLC = 3'd5;
	localparam stage_t ST_TARGET = 3'd6;
	localparam stage_t ST_DONE = 3'd7;

	// version family
	typedef logic [1:0] family_t;
	localparam family_t FAM_NONE = 2'd0;
	localparam family_t FAM_V4 = 2'd1;
	localparam family_t FAM_V6 = 2'd2;

	typedef struct packed {
		stage_t  stage;
		logic    failed;
		family_t family;
	} ctl_t;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_QINQ = 16'h88a8;

	localparam logic [15:0] FC_PROTECTED = 16'h4000;
	localparam logic [15:0] FC_ORDER = 16'h8000;
	localparam logic [15:0] FC_TO_DS = 16'h0100;
	localparam logic [15:0] FC_FROM_DS = 16'h0200;
	localparam logic [15:0] FC_QOS = 16'h0080;
	localparam logic [1:0] FC_TYPE_DATA = 2'd2;

	localparam logic [7:0] LLC_SAP = 8'haa;
	localparam logic [7:0] LLC_CTRL = 8'h03;

	localparam logic [5:0] WLAN_HDR_LEN = 6'd24;
	localparam logic [5:0] WLAN_ADDR4_LEN = 6'd6;
	localparam logic [5:0] WLAN_QOS_LEN = 6'd2;
	localparam logic [5:0] WLAN_HTC_LEN = 6'd4;
	localparam logic [15:0] RTAP_MIN_LEN = 16'd8;

	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	function automatic logic is_ip_type(input logic [15:0] t);
		return (t == ETYPE_IPV4) || (t == ETYPE_IPV6);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/link_layer_network_offset_parser_core.sv =====
`default_nettype none

// Finds the IPv4/IPv6 header in a captured frame streamed one byte per beat, for the
// link type held in register 0 (sampled at the first byte of each frame). One beat is
// accepted every cycle; the parse step sits between a one-byte input register and the
// result register, so the result for a frame is registered as its last byte leaves the
// input register, and input stalls only while a finished result waits with the last byte of
// the next frame behind it. Frames longer than the position counter report not found.
module link_layer_network_offset_parser_core #(
	parameter int POSITION_WIDTH = llnop_pkg::POSITION_WIDTH,
	localparam int NW = ((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16) + 2
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [llnop_pkg::PADDR_WIDTH-1:0]    paddr,
	input  wire logic [llnop_pkg::PDATA_WIDTH-1:0]    pwdata,
	output logic      [llnop_pkg::PDATA_WIDTH-1:0]    prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [7:0]                           data_byte,
	input  wire logic                                 last_byte,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      found,
	output logic      [15:0]                          ip_offset,
	output logic                                      ip_family
);

	logic [llnop_pkg::LINK_TYPE_WIDTH-1:0] link_type_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       adv_s1;

	logic [POSITION_WIDTH-1:0] pos_q;
	logic [15:0]               shift_q;
	logic [NW-1:0]             nfp_q;
	logic [POSITION_WIDTH-1:0] tgt_q;
	llnop_pkg::ctl_t           ctl_q;

	llnop_pkg::ctl_t           ctl_n;
	logic [POSITION_WIDTH-1:0] pos_n;
	logic [15:0]               shift_n;
	logic [NW-1:0]             nfp_n;
	logic [POSITION_WIDTH-1:0] tgt_n;
	logic                      res_found;
	logic [15:0]               res_offset;
	logic                      res_family;

	logic        out_valid_q;
	logic        found_q;
	logic [15:0] ip_offset_q;
	logic        ip_family_q;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == llnop_pkg::REG_LINK_TYPE) ?
		llnop_pkg::PDATA_WIDTH'(link_type_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= '0;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == llnop_pkg::REG_LINK_TYPE)) begin
			link_type_q <= pwdata[llnop_pkg::LINK_TYPE_WIDTH-1:0];
		end
	end

	// input register
	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	llnop_step #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_step (
		.link_type (link_type_q),
		.data_byte (data_s1),
		.pos       (pos_q),
		.shift     (shift_q),
		.nfp       (nfp_q),
		.tgt       (tgt_q),
		.ctl       (ctl_q),
		.ctl_n     (ctl_n),
		.pos_n     (pos_n),
		.shift_n   (shift_n),
		.nfp_n     (nfp_n),
		.tgt_n     (tgt_n),
		.res_found (res_found),
		.res_offset(res_offset),
		.res_family(res_family)
	);

	// frame state, cleared after each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			shift_q <= '0;
			nfp_q <= '0;
			tgt_q <= '0;
			ctl_q <= '{stage: llnop_pkg::ST_START, failed: 1'b0, family: llnop_pkg::FAM_NONE};
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q <= '0;
				shift_q <= '0;
				nfp_q <= '0;
				tgt_q <= '0;
				ctl_q <= '{stage: llnop_pkg::ST_START, failed: 1'b0,
					family: llnop_pkg::FAM_NONE};
			end else begin
				pos_q <= pos_n;
				shift_q <= shift_n;
				nfp_q <= nfp_n;
				tgt_q <= tgt_n;
				ctl_q <= ctl_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			found_q <= res_found;
			ip_offset_q <= res_offset;
			ip_family_q <= res_family;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign ip_offset = ip_offset_q;
	assign ip_family = ip_family_q;

	a_fail_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.failed |-> (ctl_q.stage == llnop_pkg::ST_DONE))
		else $error("failed frame not parked");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> ((ip_offset_q == 16'h0000) && !ip_family_q))
		else $error("not-found result carries data");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> ((pos_q == '0) && (ctl_q.stage == llnop_pkg::ST_START)))
		else $error("frame state not cleared after last byte");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(data_s1) && $stable(last_s1)))
		else $error("input register lost a beat");

endmodule

`default_nettype wire

// ===== hw/rtl/llnop_step.sv =====
`default_nettype none

module llnop_step #(
	parameter int POSITION_WIDTH = llnop_pkg::POSITION_WIDTH,
	localparam int NW = ((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16) + 2,
	localparam int OW = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16
) (
	input  wire logic [llnop_pkg::LINK_TYPE_WIDTH-1:0] link_type,
	input  wire logic [7:0]                             data_byte,
	input  wire logic [POSITION_WIDTH-1:0]              pos,
	input  wire logic [15:0]                            shift,
	input  wire logic [NW-1:0]                          nfp,
	input  wire logic [POSITION_WIDTH-1:0]              tgt,
	input  wire llnop_pkg::ctl_t                        ctl,
	output llnop_pkg::ctl_t                             ctl_n,
	output logic [POSITION_WIDTH-1:0]                   pos_n,
	output logic [15:0]                                 shift_n,
	output logic [NW-1:0]                               nfp_n,
	output logic [POSITION_WIDTH-1:0]                   tgt_n,
	output logic                                        res_found,
	output logic [15:0]                                 res_offset,
	output logic                                        res_family
);

	logic [15:0]   shift_new;
	logic [15:0]   le_word;
	logic [NW-1:0] pos_x;
	logic [NW-1:0] rel;
	logic [5:0]    mac_len;
	logic [OW-1:0] tgt_w;

	assign shift_new = {shift[7:0], data_byte};
	// 802.11 and radiotap fields are little endian
	assign le_word = {shift_new[7:0], shift_new[15:8]};
	assign pos_x = NW'(pos);
	assign rel = pos_x - nfp;

	always_comb begin
		mac_len = llnop_pkg::WLAN_HDR_LEN;
		if (((le_word & llnop_pkg::FC_TO_DS) != '0) && ((le_word & llnop_pkg::FC_FROM_DS) != '0)) begin
			mac_len = mac_len + llnop_pkg::WLAN_ADDR4_LEN;
		end
		if ((le_word & llnop_pkg::FC_QOS) != '0) begin
			mac_len = mac_len + llnop_pkg::WLAN_QOS_LEN;
		end
		if ((le_word & llnop_pkg::FC_ORDER) != '0) begin
			mac_len = mac_len + llnop_pkg::WLAN_HTC_LEN;
		end
	end

	always_comb begin
		ctl_n = ctl;
		pos_n = pos;
		shift_n = shift;
		nfp_n = nfp;
		tgt_n = tgt;
		if (pos == '1) begin
			ctl_n.failed = 1'b1;
			ctl_n.stage = llnop_pkg::ST_DONE;
		end else begin
			shift_n = shift_new;
			pos_n = pos + POSITION_WIDTH'(1);
			if (!ctl.failed) begin
				if (ctl.stage == llnop_pkg::ST_START) begin
					case (link_type)
						llnop_pkg::LT_ETHERNET: begin
							ctl_n.stage = llnop_pkg::ST_ETH;
							nfp_n = NW'(12);
						end
						llnop_pkg::LT_COOKED_V1: begin
							ctl_n.stage = llnop_pkg::ST_TYPE;
							nfp_n = NW'(14);
							tgt_n = POSITION_WIDTH'(16);
						end
						llnop_pkg::LT_COOKED_V2: begin
							ctl_n.stage = llnop_pkg::ST_TYPE;
							nfp_n = '0;
							tgt_n = POSITION_WIDTH'(20);
						end
						llnop_pkg::LT_RAW: begin
							ctl_n.stage = llnop_pkg::ST_TARGET;
							tgt_n = '0;
						end
						llnop_pkg::LT_NULL, llnop_pkg::LT_LOOP: begin
							ctl_n.stage = llnop_pkg::ST_TARGET;
							tgt_n = POSITION_WIDTH'(4);
						end
						llnop_pkg::LT_RADIOTAP: begin
							ctl_n.stage = llnop_pkg::ST_RTAP;
						end
						llnop_pkg::LT_WLAN: begin
							ctl_n.stage = llnop_pkg::ST_FC;
							nfp_n = '0;
						end
						default: begin
							ctl_n.failed = 1'b1;
							ctl_n.stage = llnop_pkg::ST_DONE;
						end
					endcase
				end
				case (ctl_n.stage)
					llnop_pkg::ST_ETH: begin
						if (pos_x == nfp_n + NW'(1)) begin
							if ((shift_new == llnop_pkg::ETYPE_VLAN) ||
							    (shift_new == llnop_pkg::ETYPE_QINQ)) begin
								nfp_n = pos_x + NW'(3);
							end else if (llnop_pkg::is_ip_type(shift_new)) begin
								tgt_n = pos + POSITION_WIDTH'(1);
								ctl_n.stage = llnop_pkg::ST_TARGET;
							end else begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end
						end
					end
					llnop_pkg::ST_TYPE: begin
						if (pos_x == nfp_n + NW'(1)) begin
							if (llnop_pkg::is_ip_type(shift_new)) begin
								ctl_n.stage = llnop_pkg::ST_TARGET;
							end else begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end
						end
					end
					llnop_pkg::ST_RTAP: begin
						if ((pos == '0) && (data_byte != 8'h00)) begin
							ctl_n.failed = 1'b1;
							ctl_n.stage = llnop_pkg::ST_DONE;
						end else if (pos == POSITION_WIDTH'(3)) begin
							if (le_word < llnop_pkg::RTAP_MIN_LEN) begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else begin
								nfp_n = NW'(le_word);
								ctl_n.stage = llnop_pkg::ST_FC;
							end
						end
					end
					llnop_pkg::ST_FC: begin
						if (pos_x == nfp_n + NW'(1)) begin
							if (((le_word & llnop_pkg::FC_PROTECTED) != '0) ||
							    (le_word[3:2] != llnop_pkg::FC_TYPE_DATA)) begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else begin
								nfp_n = nfp_n + NW'(mac_len);
								ctl_n.stage = llnop_pkg::ST_LLC;
							end
						end
					end
					llnop_pkg::ST_LLC: begin
						if (pos_x >= nfp) begin
							if (((rel == NW'(0)) || (rel == NW'(1))) &&
							    (data_byte != llnop_pkg::LLC_SAP)) begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else if ((rel == NW'(2)) && (data_byte != llnop_pkg::LLC_CTRL)) begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else if (rel == NW'(7)) begin
								if (llnop_pkg::is_ip_type(shift_new)) begin
									tgt_n = pos + POSITION_WIDTH'(1);
									ctl_n.stage = llnop_pkg::ST_TARGET;
								end else begin
									ctl_n.failed = 1'b1;
									ctl_n.stage = llnop_pkg::ST_DONE;
								end
							end
						end
					end
					llnop_pkg::ST_TARGET: begin
						if (pos == tgt_n) begin
							if (data_byte[7:4] == llnop_pkg::VER_IPV4) begin
								ctl_n.family = llnop_pkg::FAM_V4;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else if (data_byte[7:4] == llnop_pkg::VER_IPV6) begin
								ctl_n.family = llnop_pkg::FAM_V6;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end else begin
								ctl_n.failed = 1'b1;
								ctl_n.stage = llnop_pkg::ST_DONE;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign tgt_w = OW'(tgt_n);
	assign res_found = !ctl_n.failed && (ctl_n.family != llnop_pkg::FAM_NONE) &&
		(tgt_w <= OW'(16'hffff));
	assign res_offset = res_found ? tgt_w[15:0] : 16'h0000;
	assign res_family = res_found && (ctl_n.family == llnop_pkg::FAM_V6);

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	import llnop_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_UNKNOWN = 4'd8;
	localparam logic [LINK_TYPE_WIDTH-1:0] LT_TOP = 4'hf;
	localparam int NPH = 12;
	localparam int CALM_PHASE = 10;
	localparam logic [LINK_TYPE_WIDTH-1:0] PHASES [NPH] = '{
		LT_ETHERNET, LT_COOKED_V1, LT_COOKED_V2, LT_RAW, LT_NULL, LT_LOOP,
		LT_RADIOTAP, LT_WLAN, LT_UNKNOWN, LT_TOP, LT_ETHERNET, LT_WLAN
	};
	localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

	typedef struct packed {
		logic [7:0] data;
		logic       last_mark;
	} beat_t;

	typedef struct packed {
		logic        found;
		logic [15:0] offset;
		logic        family;
	} ip_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_WIDTH-1:0] paddr = '0;
	logic [PDATA_WIDTH-1:0] pwdata = '0;
	logic [PDATA_WIDTH-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic [15:0] ip_offset;
	logic ip_family;

	link_layer_network_offset_parser_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	beat_t byte_q[$];
	ip_report_t wanted_reports[$];
	logic [7:0] frame_buf[$];
	int errors = 0;
	int cycle_cnt = 0;
	int phase_bytes;
	int phase_frames;
	bit calm = 1'b0;

	// header tracker state
	logic [LINK_TYPE_WIDTH-1:0] link_cfg = LT_ETHERNET;
	logic [POSITION_WIDTH-1:0] frame_pos = '0;
	stage_t stage = ST_START;
	logic [15:0] last_two = '0;
	logic [17:0] field_at = '0;
	logic [17:0] ip_at = '0;
	logic rejected = 1'b0;
	family_t fam = FAM_NONE;

	task automatic report(input string what);
		$display("error at cycle %0d: %s", cycle_cnt, what);
		errors++;
	endtask

	task automatic reject();
		rejected = 1'b1;
		stage = ST_DONE;
	endtask

	function automatic logic ip_ethertype(input logic [15:0] t);
		return t == ETYPE_IPV4 || t == ETYPE_IPV6;
	endfunction

	task automatic parse_byte(input logic [17:0] p, input logic [7:0] b);
		logic [15:0] fc;
		logic [17:0] hl;
		logic [17:0] rel;
		if (stage == ST_START) begin
			case (link_cfg)
				LT_ETHERNET: begin
					stage = ST_ETH;
					field_at = 18'd12;
				end
				LT_COOKED_V1: begin
					stage = ST_TYPE;
					field_at = 18'd14;
					ip_at = 18'd16;
				end
				LT_COOKED_V2: begin
					stage = ST_TYPE;
					field_at = 18'd0;
					ip_at = 18'd20;
				end
				LT_RAW: begin
					stage = ST_TARGET;
					ip_at = 18'd0;
				end
				LT_NULL, LT_LOOP: begin
					stage = ST_TARGET;
					ip_at = 18'd4;
				end
				LT_RADIOTAP: stage = ST_RTAP;
				LT_WLAN: begin
					stage = ST_FC;
					field_at = 18'd0;
				end
				default: reject();
			endcase
		end
		case (stage)
			ST_ETH: if (p == field_at + 18'd1) begin
				if (last_two == ETYPE_VLAN || last_two == ETYPE_QINQ) begin
					field_at = p + 18'd3;
				end else if (ip_ethertype(last_two)) begin
					ip_at = p + 18'd1;
					stage = ST_TARGET;
				end else begin
					reject();
				end
			end
			ST_TYPE: if (p == field_at + 18'd1) begin
				if (ip_ethertype(last_two))
					stage = ST_TARGET;
				else
					reject();
			end
			ST_RTAP: begin
				if (p == 18'd0 && b != 8'h00) begin
					reject();
				end else if (p == 18'd3) begin
					hl = {2'b00, last_two[7:0], last_two[15:8]};
					if (hl < 18'(RTAP_MIN_LEN)) begin
						reject();
					end else begin
						field_at = hl;
						stage = ST_FC;
					end
				end
			end
			ST_FC: if (p == field_at + 18'd1) begin
				// frame control is little endian
				fc = {last_two[7:0], last_two[15:8]};
				if ((fc & FC_PROTECTED) != 0 || fc[3:2] != FC_TYPE_DATA) begin
					reject();
				end else begin
					hl = 18'(WLAN_HDR_LEN);
					if ((fc & FC_TO_DS) != 0 && (fc & FC_FROM_DS) != 0)
						hl += 18'(WLAN_ADDR4_LEN);
					if ((fc & FC_QOS) != 0)
						hl += 18'(WLAN_QOS_LEN);
					if ((fc & FC_ORDER) != 0)
						hl += 18'(WLAN_HTC_LEN);
					field_at = field_at + hl;
					stage = ST_LLC;
				end
			end
			ST_LLC: if (p >= field_at) begin
				rel = p - field_at;
				if ((rel == 18'd0 || rel == 18'd1) && b != LLC_SAP) begin
					reject();
				end else if (rel == 18'd2 && b != LLC_CTRL) begin
					reject();
				end else if (rel == 18'd7) begin
					if (ip_ethertype(last_two)) begin
						ip_at = p + 18'd1;
						stage = ST_TARGET;
					end else begin
						reject();
					end
				end
			end
			ST_TARGET: if (p == ip_at) begin
				if (b[7:4] == VER_IPV4) begin
					fam = FAM_V4;
					stage = ST_DONE;
				end else if (b[7:4] == VER_IPV6) begin
					fam = FAM_V6;
					stage = ST_DONE;
				end else begin
					reject();
				end
			end
			default: ;
		endcase
	endtask

	task automatic take_beat(input logic [7:0] b, input logic lastb);
		ip_report_t r;
		logic hit;
		if (frame_pos == POS_MAX) begin
			reject();
		end else begin
			last_two = {last_two[7:0], b};
			if (!rejected)
				parse_byte(18'(frame_pos), b);
			frame_pos++;
		end
		if (lastb) begin
			hit = !rejected && fam != FAM_NONE && ip_at <= 18'hffff;
			r.found = hit;
			r.offset = hit ? ip_at[15:0] : 16'd0;
			r.family = hit && fam == FAM_V6;
			wanted_reports.push_back(r);
			frame_pos = '0;
			stage = ST_START;
			last_two = '0;
			field_at = '0;
			ip_at = '0;
			rejected = 1'b0;
			fam = FAM_NONE;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				take_beat(data_byte, last_byte);
			if (!in_valid || in_ready) begin
				if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
					in_valid <= 1'b1;
					data_byte <= byte_q[0].data;
					last_byte <= byte_q[0].last_mark;
					void'(byte_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ip_report_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (wanted_reports.size() == 0) begin
					report("result beat with no frame pending");
				end else begin
					want = wanted_reports.pop_front();
					if (found !== want.found)
						report($sformatf("found %b, wanted %b", found, want.found));
					if (ip_offset !== want.offset)
						report($sformatf("ip_offset %0d, wanted %0d", ip_offset, want.offset));
					if (ip_family !== want.family)
						report($sformatf("ip_family %b, wanted %b", ip_family, want.family));
				end
			end
			out_ready <= calm || $urandom_range(99) >= 20;
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("link_layer_network_offset_parser_core: mismatch");
			$finish;
		end
	end

	task automatic write_link_type(input logic [LINK_TYPE_WIDTH-1:0] v);
		logic [PDATA_WIDTH-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_LINK_TYPE, 2'b00};
		pwdata <= PDATA_WIDTH'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		link_cfg = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_WIDTH'(v))
			report($sformatf("link_type reads %h, wrote %h", got, v));
	endtask

	task automatic add_junk(input int n);
		repeat (n) frame_buf.push_back(8'($urandom));
	endtask

	task automatic add_word(input logic [15:0] w);
		frame_buf.push_back(w[15:8]);
		frame_buf.push_back(w[7:0]);
	endtask

	task automatic add_llc(input logic [7:0] v, input bit clean);
		frame_buf.push_back((!clean && $urandom_range(15) == 0) ? 8'($urandom) : v);
	endtask

	task automatic queue_frame();
		beat_t bt;
		if (frame_buf.size() == 0)
			add_junk(1);
		foreach (frame_buf[k]) begin
			bt.data = frame_buf[k];
			bt.last_mark = (k == frame_buf.size() - 1);
			byte_q.push_back(bt);
		end
		phase_bytes += frame_buf.size();
		phase_frames++;
		frame_buf.delete();
	endtask

	function automatic logic [3:0] pick_ver();
		int r;
		r = $urandom_range(7);
		if (r < 4)
			return VER_IPV4;
		if (r < 7)
			return VER_IPV6;
		return 4'($urandom);
	endfunction

	function automatic logic [15:0] pick_etype();
		int r;
		r = $urandom_range(15);
		if (r < 7)
			return ETYPE_IPV4;
		if (r < 14)
			return ETYPE_IPV6;
		if (r == 14)
			return ETYPE_VLAN;
		return 16'($urandom);
	endfunction

	task automatic build_frame(input logic [LINK_TYPE_WIDTH-1:0] lt, input logic [3:0] ver,
			input logic [15:0] etype, input int cut, input int rt_len, input bit clean);
		int n;
		int tags;
		logic [7:0] fc_lo;
		logic [7:0] fc_hi;
		frame_buf.delete();
		case (lt)
			LT_ETHERNET: begin
				add_junk(12);
				tags = ($urandom_range(9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
				repeat (tags) begin
					add_word($urandom_range(1) ? ETYPE_VLAN : ETYPE_QINQ);
					add_junk(2);
				end
				add_word(etype);
			end
			LT_COOKED_V1: begin
				add_junk(14);
				add_word(etype);
			end
			LT_COOKED_V2: begin
				add_word(etype);
				add_junk(18);
			end
			LT_RAW: ;
			LT_NULL, LT_LOOP: add_junk(4);
			LT_RADIOTAP, LT_WLAN: begin
				if (lt == LT_RADIOTAP) begin
					if (rt_len >= 0)
						n = rt_len;
					else if (!clean && $urandom_range(11) == 0)
						n = $urandom_range(7);
					else
						n = $urandom_range(8, 16);
					frame_buf.push_back((!clean && $urandom_range(15) == 0) ?
						8'($urandom_range(1, 255)) : 8'h00);
					add_junk(1);
					frame_buf.push_back(n[7:0]);
					frame_buf.push_back(n[15:8]);
					while (frame_buf.size() < n)
						add_junk(1);
				end
				fc_lo = $urandom;
				fc_hi = $urandom;
				// mostly unprotected data frames
				if (clean || $urandom_range(7) != 0)
					fc_lo[3:2] = FC_TYPE_DATA;
				if (clean || $urandom_range(7) != 0)
					fc_hi[6] = 1'b0;
				frame_buf.push_back(fc_lo);
				frame_buf.push_back(fc_hi);
				n = 22 + ((fc_hi[0] && fc_hi[1]) ? 6 : 0) + (fc_lo[7] ? 2 : 0) + (fc_hi[7] ? 4 : 0);
				add_junk(n);
				add_llc(LLC_SAP, clean);
				add_llc(LLC_SAP, clean);
				add_llc(LLC_CTRL, clean);
				add_junk(3);
				add_word(etype);
			end
			default: add_junk($urandom_range(0, 30));
		endcase
		frame_buf.push_back({ver, 4'($urandom)});
		add_junk($urandom_range(0, 4));
		if (cut > 0)
			while (frame_buf.size() > cut)
				frame_buf.delete(frame_buf.size() - 1);
		queue_frame();
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || in_valid || wanted_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [LINK_TYPE_WIDTH-1:0] lt;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NPH; ph++) begin
			lt = PHASES[ph];
			calm = (ph == CALM_PHASE);
			write_link_type(lt);
			if (ph < CALM_PHASE) begin
				build_frame(lt, VER_IPV4, ETYPE_IPV4, 0, -1, 1'b1);
				build_frame(lt, VER_IPV4, ETYPE_IPV4, 3, -1, 1'b1);
				if (lt == LT_RAW)
					build_frame(lt, VER_IPV4, ETYPE_IPV4, 1, -1, 1'b1);
			end
			phase_bytes = 0;
			phase_frames = 0;
			while (phase_bytes < (calm ? 150 : 20) || phase_frames < 1) begin
				if ($urandom_range(99) < 8) begin
					add_junk($urandom_range(1, 40));
					queue_frame();
				end else begin
					build_frame(lt, pick_ver(), pick_etype(),
						($urandom_range(9) == 0) ? $urandom_range(1, 30) : 0, -1, 1'b0);
				end
			end
			drain();
		end
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("link_layer_network_offset_parser_core: match");
		else
			$display("link_layer_network_offset_parser_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
